// File: sv/tmdw_pkg.sv
// Package with shared constants and types for the temporal median core.
package tmdw_pkg;

    localparam int HistDepth  = 32;
    localparam int MaxPixels  = 4096;
    localparam int SlotW      = $clog2(HistDepth);
    localparam int PixW       = $clog2(MaxPixels);
    localparam int AddrW      = SlotW + PixW;
    localparam int MemDepth   = HistDepth * MaxPixels;
    localparam int DataW      = 16;
    localparam int BitW       = $clog2(DataW);
    localparam int CntW       = $clog2(HistDepth + 1);

    localparam logic [0:0] RegWindowSize   = 1'b0;
    localparam logic [0:0] RegWindowOffset = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_SEARCH,
        ST_OUT
    } state_t;

    // Control from the sequencer to the bit-serial selection unit.
    typedef struct packed {
        logic             start;
        logic             load_en;
        logic [SlotW-1:0] load_pos;
        logic             bit_step;
        logic [BitW-1:0]  bit_pos;
    } sel_ctrl_t;

endpackage

// File: sv/temporal_median_dual_window_core.sv
// Top level of the temporal median core: history memory, sequencer and APB registers.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid / in_ready       | pixel_value, pixel_index, end_of_frame
//  output   | out_valid / out_ready     | new_median, old_median
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// After reset a clearing pass writes zero to all 131072 memory words, one a cycle.
// Each transfer takes a write step, then for each of the two medians the window reads, a wait
// for the last read to land, a start step, a bit-serial search and an output step.
// A finished result waits in the output register; the next item is taken the cycle after
// it leaves, so no new item is taken before the previous result has been accepted.
module temporal_median_dual_window_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [15:0]                        pixel_value,
    input  logic [11:0]                        pixel_index,
    input  logic                               end_of_frame,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [15:0]                        new_median,
    output logic [15:0]                        old_median,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int SlotW = tmdw_pkg::SlotW;
    localparam int CntW  = tmdw_pkg::CntW;

    // Registers and state.
    tmdw_pkg::state_t state_reg, state_next;
    logic [5:0]                  size_cfg_reg;
    logic [4:0]                  off_cfg_reg;
    logic [SlotW-1:0]            newest_reg, newest_next;
    logic [tmdw_pkg::AddrW-1:0]  clr_reg, clr_next;
    logic [15:0]                 pix_val_reg;
    logic [11:0]                 pix_idx_reg;
    logic                        eof_reg;
    logic                        pass_reg, pass_next;
    logic [CntW-1:0]             step_reg, step_next;
    logic [CntW-1:0]             eff_size;
    logic [CntW-1:0]             eff_off;
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 new_med_reg, old_med_reg;

    // Memory interface.
    logic [tmdw_pkg::DataW-1:0]  mem [tmdw_pkg::MemDepth];
    logic                        mem_we;
    logic [tmdw_pkg::AddrW-1:0]  mem_waddr, mem_raddr;
    logic [tmdw_pkg::DataW-1:0]  mem_wdata, mem_rdata_reg;
    logic                        rd_pend_reg, rd_pend_next;
    logic [SlotW-1:0]            rd_pos_reg, rd_pos_next;

    tmdw_pkg::sel_ctrl_t         ctrl;
    logic [15:0]                 sel_result;
    logic                        cfg_wr;
    logic [SlotW-1:0]            age_slot;
    logic [CntW-1:0]             age;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= 6'd5;
            off_cfg_reg  <= 5'd0;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == tmdw_pkg::RegWindowSize)
        begin
            size_cfg_reg <= pwdata[5:0];
        end
        else if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == tmdw_pkg::RegWindowOffset)
        begin
            off_cfg_reg <= pwdata[4:0];
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[2])
            tmdw_pkg::RegWindowSize:   prdata = {26'd0, size_cfg_reg};
            tmdw_pkg::RegWindowOffset: prdata = {27'd0, off_cfg_reg};
            default:                   prdata = '0;
        endcase
    end

    // Clamp window size and offset.
    always_comb
    begin
        if (size_cfg_reg == 6'd0)
        begin
            eff_size = CntW'(1);
        end
        else if (size_cfg_reg > 6'(tmdw_pkg::HistDepth))
        begin
            eff_size = CntW'(tmdw_pkg::HistDepth);
        end
        else
        begin
            eff_size = CntW'(size_cfg_reg);
        end
        if (CntW'(off_cfg_reg) > CntW'(tmdw_pkg::HistDepth) - eff_size)
        begin
            eff_off = CntW'(tmdw_pkg::HistDepth) - eff_size;
        end
        else
        begin
            eff_off = CntW'(off_cfg_reg);
        end
    end

    // Slot of the sample of the current age.
    assign age      = (pass_reg ? eff_off : '0) + step_reg;
    assign age_slot = newest_reg - age[SlotW-1:0];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        newest_next    = newest_reg;
        clr_next       = clr_reg;
        pass_next      = pass_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        rd_pend_next   = 1'b0;
        rd_pos_next    = rd_pos_reg;
        mem_we         = 1'b0;
        mem_waddr      = {newest_reg, pix_idx_reg};
        mem_wdata      = pix_val_reg;
        mem_raddr      = {age_slot, pix_idx_reg};
        ctrl           = '0;
        ctrl.load_pos  = rd_pos_reg;
        ctrl.bit_pos   = step_reg[tmdw_pkg::BitW-1:0];
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        ctrl.load_en = rd_pend_reg;
        case (state_reg)
            tmdw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = tmdw_pkg::ST_IDLE;
                end
            end
            tmdw_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && !out_valid_reg)
                begin
                    state_next = tmdw_pkg::ST_WRITE;
                end
            end
            tmdw_pkg::ST_WRITE:
            begin
                mem_we     = 1'b1;
                pass_next  = 1'b0;
                step_next  = '0;
                state_next = tmdw_pkg::ST_LOAD;
            end
            tmdw_pkg::ST_LOAD:
            begin
                if (step_reg < eff_size)
                begin
                    rd_pend_next = 1'b1;
                    rd_pos_next  = step_reg[SlotW-1:0];
                    step_next    = step_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    ctrl.start = 1'b1;
                    step_next  = CntW'(tmdw_pkg::DataW - 1);
                    state_next = tmdw_pkg::ST_SEARCH;
                end
            end
            tmdw_pkg::ST_SEARCH:
            begin
                ctrl.bit_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = tmdw_pkg::ST_OUT;
                end
            end
            tmdw_pkg::ST_OUT:
            begin
                if (!pass_reg)
                begin
                    pass_next  = 1'b1;
                    step_next  = '0;
                    state_next = tmdw_pkg::ST_LOAD;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    if (eof_reg)
                    begin
                        newest_next = newest_reg + 1'b1;
                    end
                    state_next = tmdw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmdw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmdw_pkg::ST_CLEAR;
            newest_reg    <= '0;
            clr_reg       <= '0;
            pass_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_pos_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            clr_reg       <= clr_next;
            pass_reg      <= pass_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            rd_pos_reg    <= rd_pos_next;
        end
    end

    // Input capture and result registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pix_val_reg <= pixel_value;
            pix_idx_reg <= pixel_index;
            eof_reg     <= end_of_frame;
        end
        if (state_reg == tmdw_pkg::ST_OUT && !pass_reg)
        begin
            new_med_reg <= sel_result;
        end
        if (state_reg == tmdw_pkg::ST_OUT && pass_reg)
        begin
            old_med_reg <= sel_result;
        end
    end

    // History memory, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    tmdw_select u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_data (mem_rdata_reg),
        .count     (eff_size),
        .rank      (eff_size >> 1),
        .result    (sel_result)
    );

    assign out_valid  = out_valid_reg;
    assign new_median = new_med_reg;
    assign old_median = old_med_reg;

    // No transfer is taken during the clearing pass.
    a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tmdw_pkg::ST_CLEAR |-> !in_ready)
        else $error("input taken while clearing");
    // A result appears only after the second window pass.
    a_out_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pass_reg) && $past(state_reg) == tmdw_pkg::ST_OUT)
        else $error("result without both medians");
    // The newest slot moves only when a result is released.
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        newest_reg != $past(newest_reg) |-> $rose(out_valid_reg))
        else $error("slot moved outside result");

endmodule

// File: sv/tmdw_select.sv
// Bit-serial rank selection: finds the k-th largest of a sample window, one bit a cycle.
module tmdw_select
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tmdw_pkg::sel_ctrl_t                   ctrl,
    input  logic [tmdw_pkg::DataW-1:0]            load_data,
    input  logic [tmdw_pkg::CntW-1:0]             count,
    input  logic [tmdw_pkg::CntW-1:0]             rank,
    output logic [tmdw_pkg::DataW-1:0]            result
);

    logic [tmdw_pkg::DataW-1:0] sample_reg [tmdw_pkg::HistDepth];
    logic [tmdw_pkg::HistDepth-1:0] alive_reg;
    logic [tmdw_pkg::HistDepth-1:0] alive_next;
    logic [tmdw_pkg::CntW-1:0]      rank_reg;
    logic [tmdw_pkg::CntW-1:0]      rank_next;
    logic [tmdw_pkg::DataW-1:0]     result_reg;
    logic [tmdw_pkg::DataW-1:0]     result_next;
    logic [tmdw_pkg::HistDepth-1:0] ones;
    logic [tmdw_pkg::CntW-1:0]      ones_cnt;

    // Sample registers load one per cycle from memory.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            sample_reg[ctrl.load_pos] <= load_data;
        end
    end

    // Candidates with a one at the current bit.
    always_comb
    begin
        for (int i = 0; i < tmdw_pkg::HistDepth; i++)
        begin
            ones[i] = alive_reg[i] & sample_reg[i][ctrl.bit_pos];
        end
        ones_cnt = tmdw_pkg::CntW'($countones(ones));
    end

    // Narrow the candidate set, most significant bit first.
    always_comb
    begin
        alive_next  = alive_reg;
        rank_next   = rank_reg;
        result_next = result_reg;
        if (ctrl.start)
        begin
            for (int i = 0; i < tmdw_pkg::HistDepth; i++)
            begin
                alive_next[i] = (tmdw_pkg::CntW'(i) < count);
            end
            rank_next = rank;
        end
        else if (ctrl.bit_step)
        begin
            if (rank_reg < ones_cnt)
            begin
                alive_next = ones;
                result_next[ctrl.bit_pos] = 1'b1;
            end
            else
            begin
                alive_next = alive_reg & ~ones;
                rank_next  = rank_reg - ones_cnt;
                result_next[ctrl.bit_pos] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            alive_reg <= alive_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // The rank always stays inside the surviving candidate set.
    a_rank_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.bit_step && !ctrl.start |=> $countones(alive_reg) > rank_reg)
        else $error("rank left candidate set");
    // A fresh search starts with the loaded count alive.
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> $countones(alive_reg) == $past(count))
        else $error("start count mismatch");
    // Candidates only ever shrink during a search.
    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.bit_step && !ctrl.start |=> (alive_reg & ~$past(alive_reg)) == '0)
        else $error("candidate set grew");

endmodule
